### rtl/assert_macros.svh
// Assertion macros used by the top level of the positional list store.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, held off while arst_n is low.
`define PLS_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, sampled on clk, held off while arst_n is low.
`define PLS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PLS_ASSERT_IMPLY(lbl, ante, cons, msg)
`define PLS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/pls_pkg.sv
// Types, constants and codes shared by the positional list store modules.
`timescale 1ns / 1ps
package pls_pkg;

	localparam int CAPACITY = 64;
	localparam int DATA_W   = 32;
	localparam int POS_W    = 7;
	localparam int COUNT_W  = 7;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [2:0] {
		OP_ADD_FRONT = 3'd0,
		OP_ADD_END   = 3'd1,
		OP_INSERT_AT = 3'd2,
		OP_REM_FRONT = 3'd3,
		OP_REM_END   = 3'd4,
		OP_REM_AT    = 3'd5,
		OP_GET_AT    = 3'd6,
		OP_CLEAR     = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_BAD  = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic [2:0]              operation;
		logic signed [DATA_W-1:0] value;
		logic [POS_W-1:0]        position;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value_out;
		logic [1:0]              status;
		logic [COUNT_W-1:0]      count;
		logic                    empty_res;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_DRAIN,
		S_PLACE,
		S_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic setup;
		logic rd_issue;
		logic place;
		logic commit;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic fail;
		logic is_clear;
		logic is_insert;
		logic no_move;
		logic scan_last;
		logic out_busy;
	} dp_sts_t;

endpackage

### rtl/pls_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module pls_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/pls_ctrl.sv
// Controller state machine that sequences one list request at a time.
`timescale 1ns / 1ps
module pls_ctrl import pls_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_nxt = S_CHECK;
				end
			end
			S_CHECK: begin
				priority if (sts.fail || sts.is_clear) begin
					state_nxt = S_DONE;
				end else if (sts.is_insert && sts.no_move) begin
					state_nxt = S_PLACE;
				end else begin
					state_nxt = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.scan_last) begin
					state_nxt = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_nxt = sts.is_insert ? S_PLACE : S_DONE;
			end
			S_PLACE: begin
				state_nxt = S_DONE;
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd          = '0;
		req_stall    = (state_q != S_IDLE);
		cmd.load     = (state_q == S_IDLE) && req_valid;
		cmd.setup    = (state_q == S_CHECK);
		cmd.rd_issue = (state_q == S_SCAN);
		cmd.place    = (state_q == S_PLACE);
		cmd.commit   = (state_q == S_DONE) && !sts.out_busy;
	end

endmodule

### rtl/pls_dp.sv
// Datapath: request register, entry count, shift engine over the entry RAM, result register.
`timescale 1ns / 1ps
module pls_dp import pls_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  req_t    req,
	input  dp_cmd_t cmd,
	output dp_sts_t sts,
	input  logic    rsp_stall,
	output logic    rsp_valid,
	output rsp_t    rsp
);

	req_t                     req_q;
	logic [CNT_W-1:0]         count_q;
	logic [ADDR_W-1:0]        idx_q;
	logic [ADDR_W-1:0]        end_q;
	logic                     first_q;
	logic                     rd_valid_s1;
	logic [ADDR_W-1:0]        rd_addr_s1;
	logic                     first_s1;
	logic signed [DATA_W-1:0] res_q;
	rsp_t                     rsp_q;
	logic                     rsp_valid_q;

	logic [CMP_W-1:0]  count_x;
	logic [CMP_W-1:0]  pos_x;
	logic [CMP_W-1:0]  ipos;
	logic [CMP_W-1:0]  rpos;
	logic [CNT_W-1:0]  count_dec;
	logic              is_ins;
	logic              is_rem;
	logic              is_get;
	logic              is_clr;
	status_t           st;
	logic [CNT_W-1:0]  count_nxt;
	logic              capture;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic [DATA_W-1:0] ram_rdata;

	assign count_x   = CMP_W'(count_q);
	assign pos_x     = CMP_W'(req_q.position);
	assign count_dec = count_q - 1'b1;

	always_comb begin
		is_ins = 1'b0;
		is_rem = 1'b0;
		is_get = 1'b0;
		is_clr = 1'b0;
		ipos   = pos_x;
		rpos   = pos_x;
		unique case (op_t'(req_q.operation))
			OP_ADD_FRONT: begin
				is_ins = 1'b1;
				ipos   = '0;
			end
			OP_ADD_END: begin
				is_ins = 1'b1;
				ipos   = count_x;
			end
			OP_INSERT_AT: begin
				is_ins = 1'b1;
			end
			OP_REM_FRONT: begin
				is_rem = 1'b1;
				rpos   = '0;
			end
			OP_REM_END: begin
				is_rem = 1'b1;
				rpos   = CMP_W'(count_dec);
			end
			OP_REM_AT: begin
				is_rem = 1'b1;
			end
			OP_GET_AT: begin
				is_get = 1'b1;
			end
			OP_CLEAR: begin
				is_clr = 1'b1;
			end
			default: begin
				is_clr = 1'b1;
			end
		endcase
	end

	// Position is checked before fullness for inserts.
	always_comb begin
		st = ST_OK;
		if (is_ins) begin
			if (ipos > count_x) begin
				st = ST_BAD;
			end else if (count_q == CNT_W'(CAPACITY)) begin
				st = ST_FULL;
			end
		end else if (is_rem || is_get) begin
			if ((count_q == '0) || (rpos >= count_x)) begin
				st = ST_BAD;
			end
		end
	end

	always_comb begin
		sts           = '0;
		sts.fail      = (st != ST_OK);
		sts.is_clear  = is_clr;
		sts.is_insert = is_ins;
		sts.no_move   = (ipos == count_x);
		sts.scan_last = (idx_q == end_q);
		sts.out_busy  = rsp_valid_q && rsp_stall;
	end

	always_comb begin
		count_nxt = count_q;
		if (is_clr) begin
			count_nxt = '0;
		end else if (st == ST_OK && is_ins) begin
			count_nxt = count_q + 1'b1;
		end else if (st == ST_OK && is_rem) begin
			count_nxt = count_dec;
		end
	end

	// The first read of a remove or get is the result; every other read is moved
	// one slot up (insert) or down (remove).
	assign capture   = rd_valid_s1 && !is_ins && first_s1;
	assign ram_we    = (rd_valid_s1 && !capture) || cmd.place;
	assign ram_wdata = cmd.place ? DATA_W'(req_q.value) : ram_rdata;

	always_comb begin
		if (cmd.place) begin
			ram_waddr = ADDR_W'(ipos);
		end else if (is_ins) begin
			ram_waddr = rd_addr_s1 + 1'b1;
		end else begin
			ram_waddr = rd_addr_s1 - 1'b1;
		end
	end

	pls_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.rd_issue),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (cmd.setup) begin
			first_q <= 1'b1;
			if (is_ins) begin
				idx_q <= count_dec[ADDR_W-1:0];
				end_q <= ADDR_W'(ipos);
			end else begin
				idx_q <= ADDR_W'(rpos);
				end_q <= is_get ? ADDR_W'(rpos) : count_dec[ADDR_W-1:0];
			end
		end else if (cmd.rd_issue) begin
			first_q <= 1'b0;
			idx_q   <= is_ins ? (idx_q - 1'b1) : (idx_q + 1'b1);
		end
		rd_addr_s1 <= idx_q;
		first_s1   <= first_q;
		if (capture) begin
			res_q <= $signed(ram_rdata);
		end
		if (cmd.commit) begin
			rsp_q.status    <= st;
			rsp_q.count     <= COUNT_W'(count_nxt);
			rsp_q.empty_res <= (count_nxt == '0);
			if (st != ST_OK) begin
				rsp_q.value_out <= -32'sd1;
			end else if (is_rem || is_get) begin
				rsp_q.value_out <= res_q;
			end else begin
				rsp_q.value_out <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rd_valid_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.rd_issue;
			if (cmd.commit) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### rtl/positional_list_store.sv
// Top level of the positional list store: controller, datapath and checks.
`timescale 1ns / 1ps
`include "assert_macros.svh"
//
//  Channel   Direction  Handshake              Payload
//  req       in         req_valid / req_stall  req_t: operation, value, position
//  rsp       out        rsp_valid / rsp_stall  rsp_t: value_out, status, count, empty_res
//
// A request passes through an accept state, a check state, one RAM read per entry moved
// (a remove or get also reads its own slot), a drain, a place for inserts and a
// commit; an error or clear goes from check straight to commit, and an insert
// that moves nothing skips the reads and the drain. The entry RAM moves one entry a cycle.
// Reset clears the controller, the count and the result valid flag, not the RAM.
// The next request is taken while a result waits; its commit waits out rsp_stall.
module positional_list_store import pls_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	// Command and status groups between the controller and the datapath.
	dp_cmd_t cmd;
	dp_sts_t sts;

	// A result that carries an error status.
	logic rsp_err;

	// The controller walks each request through check, shift and commit.
	pls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath owns the entry RAM, the count and the result register.
	pls_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.sts      (sts),
		.rsp_stall(rsp_stall),
		.rsp_valid(rsp_valid),
		.rsp      (rsp)
	);

	assign rsp_err = rsp_valid && (rsp.status != ST_OK);

	// After a request is accepted the block is busy for at least the check cycle.
	`PLS_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "stall missing")
	// Any failed request answers with the error value.
	`PLS_ASSERT_IMPLY(a_err_value, rsp_err, rsp.value_out == -32'sd1, "error without -1")
	// A nonzero count never comes with the empty flag.
	`PLS_ASSERT_IMPLY(a_empty_flag, rsp_valid && (rsp.count != '0), !rsp.empty_res, "empty flag")

endmodule

### test/testbench.sv
// Self-checking testbench for the positional list store: random and directed requests.
`timescale 1ns / 1ps

module testbench;
	import pls_pkg::*;

	// The longest a correct request can take grows with one entry move per
	// stored entry, so the settle time at the end is derived from the
	// capacity, while the watchdog limit is a constant of its own.
	localparam int SETTLE_CYCLES  = CAPACITY + 16;
	localparam int LONG_HOLD      = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 1250;
	localparam int HOLD_AT_RSP    = 500;

	// Scoreboard: keeps its own copy of the list and a queue of the responses
	// that the accepted requests must produce, in order.
	class list_scoreboard;
		logic signed [DATA_W-1:0] contents[$];
		rsp_t expected_rsp[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function int depth();
			return contents.size();
		endfunction

		// Works out the response to an accepted request and updates the list.
		function void note_request(req_t r);
			rsp_t e;
			int n;
			int pos;
			n = contents.size();
			e.value_out = '0;
			e.status = ST_OK;
			case (op_t'(r.operation))
				OP_ADD_FRONT, OP_ADD_END, OP_INSERT_AT: begin
					if (op_t'(r.operation) == OP_ADD_FRONT)
						pos = 0;
					else if (op_t'(r.operation) == OP_ADD_END)
						pos = n;
					else
						pos = int'(r.position);
					// A bad position wins over a full store.
					if (pos > n)
						e.status = ST_BAD;
					else if (n >= CAPACITY)
						e.status = ST_FULL;
					else
						contents.insert(pos, r.value);
				end
				OP_REM_FRONT, OP_REM_END, OP_REM_AT: begin
					if (op_t'(r.operation) == OP_REM_FRONT)
						pos = 0;
					else if (op_t'(r.operation) == OP_REM_END)
						pos = n - 1;
					else
						pos = int'(r.position);
					if (n == 0 || pos >= n) begin
						e.status = ST_BAD;
					end else begin
						e.value_out = contents[pos];
						contents.delete(pos);
					end
				end
				OP_GET_AT: begin
					if (n == 0 || r.position >= n)
						e.status = ST_BAD;
					else
						e.value_out = contents[r.position];
				end
				default: begin
					contents.delete();
				end
			endcase
			if (e.status != ST_OK)
				e.value_out = -1;
			e.count = COUNT_W'(contents.size());
			e.empty_res = (contents.size() == 0);
			expected_rsp.push_back(e);
		endfunction

		function void report(string field, longint want, longint got);
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			errors++;
		endfunction

		// Compares an accepted response with the oldest expectation.
		function void check_response(rsp_t got);
			rsp_t e;
			if (expected_rsp.size() == 0) begin
				$display("%0t: response with none expected, expected nothing, actual %h",
					$time, got);
				errors++;
				return;
			end
			e = expected_rsp.pop_front();
			if (got.value_out !== e.value_out)
				report("value_out", longint'(e.value_out), longint'(got.value_out));
			if (got.status !== e.status)
				report("status", longint'(e.status), longint'(got.status));
			if (got.count !== e.count)
				report("count", longint'(e.count), longint'(got.count));
			if (got.empty_res !== e.empty_res)
				report("empty_res", longint'(e.empty_res), longint'(got.empty_res));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	list_scoreboard sb;

	// When set, neither side inserts idle cycles, so the block runs back to back.
	logic no_idle;
	// Number of responses taken by the receiver so far.
	int rsp_taken;

	positional_list_store u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic req_t make_req(op_t op, logic signed [DATA_W-1:0] v, int pos);
		req_t r;
		r.operation = op;
		r.value = v;
		r.position = POS_W'(pos);
		return r;
	endfunction

	// Offers one request after a random gap and holds it until it is taken.
	// Inputs change only at the falling edge; the handshake is judged with
	// the values that stood just before the rising edge.
	task automatic send_request(req_t r);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req = r;
		req_valid = 1'b1;
		do @(posedge clk); while (req_stall);
		sb.note_request(r);
		@(negedge clk);
	endtask

	// Short directed run: empty-list errors, extreme values and positions,
	// inserts at both ends and in the middle, bad positions, and clear.
	task automatic run_directed();
		send_request(make_req(OP_GET_AT, 0, 0));
		send_request(make_req(OP_REM_FRONT, 0, 0));
		send_request(make_req(OP_REM_END, 0, 0));
		send_request(make_req(OP_REM_AT, 0, 0));
		send_request(make_req(OP_INSERT_AT, 32'sd5, 1));
		send_request(make_req(OP_INSERT_AT, 32'sh7fffffff, 0));
		send_request(make_req(OP_ADD_FRONT, 32'sh80000000, 64));
		send_request(make_req(OP_ADD_END, -1, 0));
		send_request(make_req(OP_ADD_END, 0, 127));
		send_request(make_req(OP_INSERT_AT, 32'sh5a5a5a5a, 2));
		send_request(make_req(OP_INSERT_AT, 32'sh12345678, 6));
		send_request(make_req(OP_INSERT_AT, 32'sha5a5a5a5, 5));
		send_request(make_req(OP_GET_AT, 0, 0));
		send_request(make_req(OP_GET_AT, 0, 5));
		send_request(make_req(OP_GET_AT, 0, 6));
		send_request(make_req(OP_GET_AT, 0, 64));
		send_request(make_req(OP_REM_AT, 0, 2));
		send_request(make_req(OP_REM_AT, 0, 64));
		send_request(make_req(OP_REM_FRONT, 0, 0));
		send_request(make_req(OP_REM_END, 0, 0));
		send_request(make_req(OP_CLEAR, 32'sh7fffffff, 64));
		send_request(make_req(OP_CLEAR, 0, 0));
		send_request(make_req(OP_GET_AT, 0, 0));
		send_request(make_req(OP_ADD_END, 32'sh0f0f0f0f, 0));
	endtask

	// Random requests in phases: growing phases fill the list until it is
	// full, shrinking phases drain it until it is empty, and mixed phases
	// sit in between. Most positions are legal for the current length so
	// the shifting logic gets real work; the rest are drawn from 0 to 64.
	task automatic run_random();
		req_t r;
		int phase;
		int pick;
		int n;
		op_t op;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			phase = (i / 125) % 4;
			no_idle = ((i / 100) % 5 == 4);
			n = sb.depth();
			pick = $urandom_range(0, 99);
			if (phase == 0)
				op = (pick < 80) ? op_t'($urandom_range(0, 2)) : op_t'($urandom_range(3, 6));
			else if (phase == 2)
				op = (pick < 80) ? op_t'($urandom_range(3, 5)) : op_t'($urandom_range(0, 2));
			else if (pick < 2)
				op = OP_CLEAR;
			else
				op = op_t'($urandom_range(0, 6));
			r.operation = op;
			pick = $urandom_range(0, 99);
			if (pick < 5)
				r.value = 32'sh7fffffff;
			else if (pick < 10)
				r.value = 32'sh80000000;
			else if (pick < 13)
				r.value = -1;
			else
				r.value = $urandom;
			pick = $urandom_range(0, 99);
			if (pick < 15)
				r.position = POS_W'($urandom_range(0, 64));
			else if (op == OP_INSERT_AT)
				r.position = POS_W'($urandom_range(0, n));
			else
				r.position = (n > 0) ? POS_W'($urandom_range(0, n - 1)) : '0;
			send_request(r);
		end
		req_valid = 1'b0;
	endtask

	// Receiver: waits a random number of cycles before each response, and once
	// holds off for a long stretch so the block fills up and stalls requests.
	initial begin
		int hold;
		rsp_stall = 1'b0;
		rsp_taken = 0;
		@(posedge arst_n);
		forever begin
			hold = no_idle ? 0 : $urandom_range(0, 6);
			if (rsp_taken == HOLD_AT_RSP)
				hold = LONG_HOLD;
			if (hold > 0) begin
				rsp_stall = 1'b1;
				repeat (hold) @(negedge clk);
			end
			rsp_stall = 1'b0;
			do @(posedge clk); while (!rsp_valid);
			sb.check_response(rsp);
			rsp_taken++;
			@(negedge clk);
		end
	end

	// Watchdog: counts cycles in which neither channel moves anything.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("Mismatches found");
		$finish;
	end

	// Main sequence: reset once, directed requests, random requests, then
	// wait for every expected response and a settle period before judging.
	initial begin
		sb = new();
		no_idle = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		run_directed();
		run_random();
		while (sb.expected_rsp.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.expected_rsp.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl
rtl/pls_pkg.sv
rtl/pls_ram.sv
rtl/pls_ctrl.sv
rtl/pls_dp.sv
rtl/positional_list_store.sv
test/testbench.sv
